@@ hdl/upl_pkg.sv @@
package upl_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SIZE_BITS   = 16;
  localparam int unsigned NUMBER_BITS = 62;
  localparam int unsigned FRAMES_W    = 32;
  localparam int unsigned BYTES_W     = 32;
  localparam int unsigned LIMIT_W     = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    OP_TRACK  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_STATE     = 3'd2,
    ST_LIMIT     = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PKT_CAP   = 2'd0,
    CFG_RETX_MASK = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [LIMIT_W-1:0]  pkt_cap;
    logic [FRAMES_W-1:0] retransmit_mask;
  } cfg_t;

  typedef struct packed {
    op_e                    op;
    logic [NUMBER_BITS-1:0] number;
    logic [SIZE_BITS-1:0]   size;
    logic [FRAMES_W-1:0]    frames;
  } cmd_t;

  typedef struct packed {
    logic [NUMBER_BITS-1:0] number;
    logic [SIZE_BITS-1:0]   size;
    logic [FRAMES_W-1:0]    frames;
  } entry_t;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [SIZE_BITS-1:0] found_size;
    logic [COUNT_W-1:0]   tracked_count;
    logic [BYTES_W-1:0]   flight_bytes;
    logic [COUNT_W-1:0]   retx_count;
    logic [BYTES_W-1:0]   retx_bytes;
  } res_t;

endpackage

@@ hdl/upl_ram.sv @@
module upl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/upl_ctrl.sv @@
module upl_ctrl import upl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  cmd_t             cmd_i,
  input  cfg_t             cfg_i,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  entry_t           rd_data_i,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_addr_o,
  output entry_t           wr_data_o,
  output logic             res_valid_o,
  output res_t             res_o
);

  state_e                 state_q, state_d;
  cmd_t                   cmd_q, cmd_d;
  logic [IDX_W-1:0]       addr_q, addr_d;
  logic                   issue_q, issue_d;
  logic                   pvld_q, pvld_d;
  logic [IDX_W-1:0]       pidx_q, pidx_d;
  logic                   hit_q, hit_d;
  logic [IDX_W-1:0]       hidx_q, hidx_d;
  logic [SIZE_BITS-1:0]   ent_size_q, ent_size_d;
  logic [FRAMES_W-1:0]    ent_frames_q, ent_frames_d;
  logic                   free_q, free_d;
  logic [IDX_W-1:0]       fidx_q, fidx_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [BYTES_W-1:0]     bytes_q, bytes_d;
  logic [COUNT_W-1:0]     rcount_q, rcount_d;
  logic [BYTES_W-1:0]     rbytes_q, rbytes_d;
  res_t                   res_q, res_d;
  logic                   res_valid_q, res_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= 1'b0;
      pvld_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      bytes_q     <= '0;
      rcount_q    <= '0;
      rbytes_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      pvld_q      <= pvld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      bytes_q     <= bytes_d;
      rcount_q    <= rcount_d;
      rbytes_q    <= rbytes_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    addr_q       <= addr_d;
    pidx_q       <= pidx_d;
    hidx_q       <= hidx_d;
    ent_size_q   <= ent_size_d;
    ent_frames_q <= ent_frames_d;
    fidx_q       <= fidx_d;
    res_q        <= res_d;
  end

  always_comb begin
    logic                 hit;
    logic                 last;
    logic                 retx_new;
    logic                 retx_old;
    logic [BYTES_W:0]     sum_all;
    logic [BYTES_W:0]     sum_retx;
    logic [BYTES_W-1:0]   size_ext;
    logic [BYTES_W-1:0]   ent_ext;

    state_d      = state_q;
    cmd_d        = cmd_q;
    addr_d       = addr_q;
    issue_d      = issue_q;
    pvld_d       = pvld_q;
    pidx_d       = pidx_q;
    hit_d        = hit_q;
    hidx_d       = hidx_q;
    ent_size_d   = ent_size_q;
    ent_frames_d = ent_frames_q;
    free_d       = free_q;
    fidx_d       = fidx_q;
    valid_d      = valid_q;
    count_d      = count_q;
    bytes_d      = bytes_q;
    rcount_d     = rcount_q;
    rbytes_d     = rbytes_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;
    rd_en_o      = 1'b0;
    wr_en_o      = 1'b0;

    hit      = pvld_q && valid_q[pidx_q] && (rd_data_i.number == cmd_q.number);
    last     = pvld_q && (pidx_q == IDX_W'(TABLE_DEPTH - 1));
    retx_new = |(cmd_q.frames & cfg_i.retransmit_mask);
    retx_old = |(ent_frames_q & cfg_i.retransmit_mask);
    size_ext = BYTES_W'(cmd_q.size);
    ent_ext  = BYTES_W'(ent_size_q);
    sum_all  = {1'b0, bytes_q} + {1'b0, size_ext};
    sum_retx = {1'b0, rbytes_q} + {1'b0, size_ext};

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          addr_d  = '0;
          issue_d = 1'b1;
          pvld_d  = 1'b0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          if (cmd_i.op == OP_CLEAR ||
              (cmd_i.op == OP_TRACK &&
               (cfg_i.pkt_cap == '0 || cmd_i.number == '0))) begin
            state_d = S_FIN;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en_o = issue_q;
        pvld_d  = 1'b0;
        if (pvld_q && !valid_q[pidx_q] && !free_q) begin
          free_d = 1'b1;
          fidx_d = pidx_q;
        end
        if (hit || last) begin
          state_d = S_FIN;
          issue_d = 1'b0;
          if (hit) begin
            hit_d        = 1'b1;
            hidx_d       = pidx_q;
            ent_size_d   = rd_data_i.size;
            ent_frames_d = rd_data_i.frames;
          end
        end else if (issue_q) begin
          pvld_d  = 1'b1;
          pidx_d  = addr_q;
          addr_d  = addr_q + IDX_W'(1);
          issue_d = (addr_q != IDX_W'(TABLE_DEPTH - 1));
        end
      end
      S_FIN: begin
        state_d          = S_IDLE;
        res_valid_d      = 1'b1;
        res_d.status     = ST_OK;
        res_d.found      = 1'b0;
        res_d.found_size = '0;
        unique case (cmd_q.op)
          OP_TRACK: begin
            if (cfg_i.pkt_cap == '0 || cmd_q.number == '0) begin
              res_d.status = ST_INVALID;
            end else if (hit_q) begin
              res_d.status = ST_STATE;
            end else if (count_q >= COUNT_W'(cfg_i.pkt_cap) || !free_q) begin
              res_d.status = ST_LIMIT;
            end else if (sum_all[BYTES_W] || (retx_new && sum_retx[BYTES_W])) begin
              res_d.status = ST_OVERFLOW;
            end else begin
              wr_en_o         = 1'b1;
              valid_d[fidx_q] = 1'b1;
              count_d         = count_q + COUNT_W'(1);
              bytes_d         = sum_all[BYTES_W-1:0];
              if (retx_new) begin
                rcount_d = rcount_q + COUNT_W'(1);
                rbytes_d = sum_retx[BYTES_W-1:0];
              end
            end
          end
          OP_REMOVE: begin
            if (!hit_q) begin
              res_d.status = ST_NOT_FOUND;
            end else if (count_q == '0 || ent_ext > bytes_q ||
                         (retx_old && (rcount_q == '0 || ent_ext > rbytes_q))) begin
              res_d.status = ST_STATE;
            end else begin
              valid_d[hidx_q] = 1'b0;
              count_d         = count_q - COUNT_W'(1);
              bytes_d         = bytes_q - ent_ext;
              if (retx_old) begin
                rcount_d = rcount_q - COUNT_W'(1);
                rbytes_d = rbytes_q - ent_ext;
              end
            end
          end
          OP_FIND: begin
            if (hit_q) begin
              res_d.found      = 1'b1;
              res_d.found_size = ent_size_q;
            end else begin
              res_d.status = ST_NOT_FOUND;
            end
          end
          OP_CLEAR: begin
            valid_d  = '0;
            count_d  = '0;
            bytes_d  = '0;
            rcount_d = '0;
            rbytes_d = '0;
          end
          default: ;
        endcase
        res_d.tracked_count = count_d;
        res_d.flight_bytes  = bytes_d;
        res_d.retx_count    = rcount_d;
        res_d.retx_bytes    = rbytes_d;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o           = (state_q != S_IDLE);
  assign rd_addr_o        = addr_q;
  assign wr_addr_o        = fidx_q;
  assign wr_data_o.number = cmd_q.number;
  assign wr_data_o.size   = cmd_q.size;
  assign wr_data_o.frames = cmd_q.frames;
  assign res_valid_o      = res_valid_q;
  assign res_o            = res_q;

  // the result strobe follows the finish step only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == S_FIN))
    else $error("result strobe without finish step");

  // live entries and packet count stay in step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("valid bits disagree with packet count");

  // a track never overwrites a live entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (free_q && !valid_q[fidx_q]))
    else $error("write to a live entry");

endmodule

@@ hdl/unacked_packet_ledger.sv @@
// channel   direction  handshake                      payload
// request   in         start high while busy low      opcode, number, sizes, flags
// result    out        done_o one cycle, no stall     status, found, sizes, totals
// config    in         cfg_valid_i and cfg_ready_o    cfg_index_i, cfg_data_i
//
// a lookup walks the entry memory one address a cycle through its registered read port
// track, remove and find scan the table up to its last address, stopping early on a
// hit; clear and tracks refused for a zero limit or number skip the scan
// the next request is taken in the cycle the result is shown
// reset empties the table and totals at once; limit 64, mask zero
// the receiver cannot stall, so done_o is never held
module unacked_packet_ledger import upl_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             opcode_i,
  input  logic [NUMBER_BITS-1:0] pkt_num_i,
  input  logic [SIZE_BITS-1:0]   plain_size_i,
  input  logic [SIZE_BITS-1:0]   sealed_size_i,
  input  logic                   encrypted_i,
  input  logic [FRAMES_W-1:0]    frame_types_i,
  output logic                   done_o,
  output logic [2:0]             status_o,
  output logic                   found_o,
  output logic [SIZE_BITS-1:0]   found_size_o,
  output logic [COUNT_W-1:0]     tracked_count_o,
  output logic [BYTES_W-1:0]     flight_bytes_o,
  output logic [COUNT_W-1:0]     retx_count_o,
  output logic [BYTES_W-1:0]     retx_bytes_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t             cfg_q;
  cmd_t             cmd;
  res_t             res;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pkt_cap         <= LIMIT_W'(TABLE_DEPTH);
      cfg_q.retransmit_mask <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PKT_CAP:   cfg_q.pkt_cap         <= cfg_data_i[LIMIT_W-1:0];
        CFG_RETX_MASK: cfg_q.retransmit_mask <= cfg_data_i[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  assign cmd.op     = op_e'(opcode_i);
  assign cmd.number = pkt_num_i;
  assign cmd.size   = encrypted_i ? sealed_size_i : plain_size_i;
  assign cmd.frames = frame_types_i;

  upl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .res_valid_o (done_o),
    .res_o       (res)
  );

  upl_ram #(
    .Width($bits(entry_t)),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign status_o        = res.status;
  assign found_o         = res.found;
  assign found_size_o    = res.found_size;
  assign tracked_count_o = res.tracked_count;
  assign flight_bytes_o  = res.flight_bytes;
  assign retx_count_o    = res.retx_count;
  assign retx_bytes_o    = res.retx_bytes;

endmodule
